/* design/tct_pkg.sv */
// Package for the terrain cell triangulator.
// Payload structs, controller/datapath command types and fixed constants.
// Depends on nothing.
`default_nettype none

package tct_pkg;

    localparam int GRID_BITS   = 10;
    localparam int HEIGHT_BITS = 12;
    localparam int NORM_BITS   = 16;
    localparam int NORM_ONE    = 16384;
    localparam int VERTS       = 6;
    localparam int SRCH_BITS   = 15;   // search value 0..NORM_ONE
    localparam int BIT_W       = 4;    // index of search bit
    localparam int VTX_W       = 3;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic [GRID_BITS-1:0]   cell_x;
        logic [GRID_BITS-1:0]   cell_y;
        logic [HEIGHT_BITS-1:0] height_a;
        logic [HEIGHT_BITS-1:0] height_b;
        logic [HEIGHT_BITS-1:0] height_c;
        logic [HEIGHT_BITS-1:0] height_d;
        logic                   first_cell;
    } cell_t;

    typedef struct packed {
        logic [GRID_BITS:0]           pos_x;
        logic [GRID_BITS:0]           pos_y;
        logic [HEIGHT_BITS-1:0]       pos_z;
        logic signed [NORM_BITS-1:0]  normal_x;
        logic signed [NORM_BITS-1:0]  normal_y;
        logic signed [NORM_BITS-1:0]  normal_z;
        logic                         diagonal_bd;
        logic [HEIGHT_BITS-1:0]       patch_max_height;
        logic                         last_vertex;
    } vertex_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             tri_sel;
        logic             sq_p;
        logic             sq_q;
        logic             sum_s;
        logic             init;
        logic [1:0]       comp;
        logic             mul_t2;
        logic             mul_lo;
        logic             mul_hi;
        logic             cmp;
        logic             store;
        logic [BIT_W-1:0] bit_idx;
        logic [VTX_W-1:0] vtx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cand_over;
    } stat_t;

endpackage

`default_nettype wire

/* design/tct_datapath.sv */
// Datapath of the terrain cell triangulator: cell registers, shared multiplier,
// bit-serial normalisation search and vertex output mux.
// Depends on tct_pkg.
`default_nettype none

module tct_datapath
    import tct_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cell_t   cell_data,
    input  wire cmd_t    cmd,
    output stat_t        stat,
    output vertex_t      vertex
);

    localparam int HB    = HEIGHT_BITS;
    localparam int D_W   = HB + 1;
    localparam int SQ_W  = 2 * HB;
    localparam int S_W   = 2 * HB + 1;
    localparam int SL_W  = (S_W + 1) / 2;
    localparam int SH_W  = S_W - SL_W;
    localparam int T2_W  = 2 * SRCH_BITS;
    localparam int MA_W  = (T2_W > HB) ? T2_W : HB;
    localparam int MB_T  = (SL_W > HB) ? SL_W : HB;
    localparam int MB_W  = (MB_T > SRCH_BITS) ? MB_T : SRCH_BITS;
    localparam int PR_W  = MA_W + MB_W;
    localparam int P_W   = T2_W + S_W;
    localparam int SHIFT = T2_W;

    function automatic logic [HB-1:0] mag_of(input logic signed [D_W-1:0] v);
        logic signed [D_W-1:0] a;
        a = (v < 0) ? -v : v;
        return a[HB-1:0];
    endfunction

    // cell registers
    logic [GRID_BITS-1:0]    x_reg, y_reg;
    logic [HB-1:0]           ha_reg, hb_reg, hc_reg, hd_reg;
    logic                    bd_reg;
    logic [HB-1:0]           max_reg;
    logic signed [D_W-1:0]   p1_reg, q1_reg, p2_reg, q2_reg;
    logic [SQ_W-1:0]         pp_reg, qq_reg, mag2_reg;
    logic [S_W-1:0]          s_reg;
    logic                    neg_reg;
    logic [SRCH_BITS-1:0]    m_reg;
    logic [T2_W-1:0]         t2_reg;
    logic [T2_W+SL_W-1:0]    pl_reg;
    logic [T2_W+SH_W-1:0]    ph_reg;
    logic [NORM_BITS-1:0]    n_reg [2][3];

    logic signed [D_W-1:0]   p_sel, q_sel;
    logic [HB-1:0]           p_mag, q_mag;
    logic [MA_W-1:0]         mul_a;
    logic [MB_W-1:0]         mul_b;
    logic [PR_W-1:0]         prod;
    logic [SRCH_BITS-1:0]    cand, t_val;
    logic [P_W-1:0]          lhs, rhs;
    logic [HB:0]             dac, dbd;
    logic [NORM_BITS-1:0]    res;

    assign p_sel = cmd.tri_sel ? p2_reg : p1_reg;
    assign q_sel = cmd.tri_sel ? q2_reg : q1_reg;
    assign p_mag = mag_of(p_sel);
    assign q_mag = mag_of(q_sel);

    // search candidate and its odd test value 2*cand-1
    assign cand  = m_reg | (SRCH_BITS'(1) << cmd.bit_idx);
    assign t_val = SRCH_BITS'(({1'b0, cand} << 1) - (SRCH_BITS + 1)'(1));
    assign stat.cand_over = (cand > SRCH_BITS'(NORM_ONE));

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_p)
        begin
            mul_a = MA_W'(p_mag);
            mul_b = MB_W'(p_mag);
        end
        else if (cmd.sq_q)
        begin
            mul_a = MA_W'(q_mag);
            mul_b = MB_W'(q_mag);
        end
        else if (cmd.mul_t2)
        begin
            mul_a = MA_W'(t_val);
            mul_b = MB_W'(t_val);
        end
        else if (cmd.mul_lo)
        begin
            mul_a = MA_W'(t2_reg);
            mul_b = MB_W'(s_reg[SL_W-1:0]);
        end
        else if (cmd.mul_hi)
        begin
            mul_a = MA_W'(t2_reg);
            mul_b = MB_W'(s_reg[S_W-1:SL_W]);
        end
    end

    assign prod = PR_W'(mul_a) * PR_W'(mul_b);

    // t^2 * s against (mag * 2^15)^2, rounding bound of the normal component
    assign lhs = (P_W'(ph_reg) << SL_W) + P_W'(pl_reg);
    assign rhs = P_W'(mag2_reg) << SHIFT;

    assign res = neg_reg ? NORM_BITS'(-{1'b0, m_reg}) : NORM_BITS'(m_reg);

    assign dac = (ha_reg > hc_reg) ? (HB + 1)'(ha_reg - hc_reg) : (HB + 1)'(hc_reg - ha_reg);
    assign dbd = (hb_reg > hd_reg) ? (HB + 1)'(hb_reg - hd_reg) : (HB + 1)'(hd_reg - hb_reg);

    // patch maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= '0;
        end
        else if (cmd.load)
        begin
            if (cell_data.first_cell || (cell_data.height_a > max_reg))
                max_reg <= cell_data.height_a;
        end
    end

    // cell capture, diagonal choice and search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg  <= cell_data.cell_x;
            y_reg  <= cell_data.cell_y;
            ha_reg <= cell_data.height_a;
            hb_reg <= cell_data.height_b;
            hc_reg <= cell_data.height_c;
            hd_reg <= cell_data.height_d;
        end
        if (cmd.sq_p)
        begin
            // diagonal choice and the q edge differences settle here from the held heights
            bd_reg <= (dac > dbd);
        end
        if (cmd.load)
        begin
            p1_reg <= D_W'(cell_data.height_a) - D_W'(cell_data.height_b);
            p2_reg <= D_W'(cell_data.height_d) - D_W'(cell_data.height_c);
        end
        if (cmd.sq_p)
        begin
            if (dac > dbd)
            begin
                q1_reg <= D_W'(ha_reg) - D_W'(hd_reg);
                q2_reg <= D_W'(hb_reg) - D_W'(hc_reg);
            end
            else
            begin
                q1_reg <= D_W'(hb_reg) - D_W'(hc_reg);
                q2_reg <= D_W'(ha_reg) - D_W'(hd_reg);
            end
            pp_reg <= prod[SQ_W-1:0];
        end
        if (cmd.sq_q)
            qq_reg <= prod[SQ_W-1:0];
        if (cmd.sum_s)
            s_reg <= S_W'(pp_reg) + S_W'(qq_reg) + S_W'(1);
        if (cmd.init)
        begin
            m_reg <= '0;
            unique case (cmd.comp)
                COMP_X:
                begin
                    mag2_reg <= pp_reg;
                    neg_reg  <= p_sel[D_W-1];
                end
                COMP_Y:
                begin
                    mag2_reg <= qq_reg;
                    neg_reg  <= q_sel[D_W-1];
                end
                default:
                begin
                    mag2_reg <= SQ_W'(1);
                    neg_reg  <= 1'b0;
                end
            endcase
        end
        if (cmd.mul_t2)
            t2_reg <= prod[T2_W-1:0];
        if (cmd.mul_lo)
            pl_reg <= prod[T2_W+SL_W-1:0];
        if (cmd.mul_hi)
            ph_reg <= prod[T2_W+SH_W-1:0];
        if (cmd.cmp && (lhs <= rhs))
            m_reg <= cand;
        if (cmd.store)
            n_reg[cmd.tri_sel][cmd.comp] <= res;
    end

    // vertex output mux
    always_comb
    begin
        logic [1:0] corner;
        logic       second;
        second = (cmd.vtx >= VTX_W'(3));
        case (cmd.vtx)
            3'd0:    corner = 2'd0;
            3'd1:    corner = 2'd1;
            3'd2:    corner = bd_reg ? 2'd3 : 2'd2;
            3'd3:    corner = bd_reg ? 2'd1 : 2'd2;
            3'd4:    corner = bd_reg ? 2'd2 : 2'd3;
            default: corner = bd_reg ? 2'd3 : 2'd0;
        endcase
        vertex.pos_x = (corner == 2'd1 || corner == 2'd2)
                     ? (GRID_BITS + 1)'(x_reg) + (GRID_BITS + 1)'(1)
                     : (GRID_BITS + 1)'(x_reg);
        vertex.pos_y = (corner == 2'd2 || corner == 2'd3)
                     ? (GRID_BITS + 1)'(y_reg) + (GRID_BITS + 1)'(1)
                     : (GRID_BITS + 1)'(y_reg);
        case (corner)
            2'd0:    vertex.pos_z = ha_reg;
            2'd1:    vertex.pos_z = hb_reg;
            2'd2:    vertex.pos_z = hc_reg;
            default: vertex.pos_z = hd_reg;
        endcase
        vertex.normal_x         = n_reg[second][COMP_X];
        vertex.normal_y         = n_reg[second][COMP_Y];
        vertex.normal_z         = n_reg[second][COMP_Z];
        vertex.diagonal_bd      = bd_reg;
        vertex.patch_max_height = max_reg;
        vertex.last_vertex      = (cmd.vtx == VTX_W'(VERTS - 1));
    end

endmodule

`default_nettype wire

/* design/tct_ctrl.sv */
// Controller of the terrain cell triangulator: sequences squaring, the
// bit-serial normal search per component and the six-vertex emission.
// Depends on tct_pkg.
`default_nettype none

module tct_ctrl
    import tct_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQP   = 4'd1;
    localparam logic [3:0] ST_SQQ   = 4'd2;
    localparam logic [3:0] ST_SUMS  = 4'd3;
    localparam logic [3:0] ST_INIT  = 4'd4;
    localparam logic [3:0] ST_TRY   = 4'd5;
    localparam logic [3:0] ST_MLO   = 4'd6;
    localparam logic [3:0] ST_MHI   = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;
    localparam logic [3:0] ST_EMIT  = 4'd10;

    localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(SRCH_BITS - 1);

    logic [3:0]       state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [1:0]       comp_reg, comp_next;
    logic             tri_reg, tri_next;
    logic [VTX_W-1:0] vtx_reg, vtx_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
            comp_reg  <= COMP_X;
            tri_reg   <= 1'b0;
            vtx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
            comp_reg  <= comp_next;
            tri_reg   <= tri_next;
            vtx_reg   <= vtx_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        bit_next   = bit_reg;
        comp_next  = comp_reg;
        tri_next   = tri_reg;
        vtx_next   = vtx_reg;
        cmd         = '0;
        cmd.tri_sel = tri_reg;
        cmd.comp    = comp_reg;
        cmd.bit_idx = bit_reg;
        cmd.vtx     = vtx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    tri_next   = 1'b0;
                    comp_next  = COMP_X;
                    state_next = ST_SQP;
                end
            end
            ST_SQP:
            begin
                cmd.sq_p   = 1'b1;
                state_next = ST_SQQ;
            end
            ST_SQQ:
            begin
                cmd.sq_q   = 1'b1;
                state_next = ST_SUMS;
            end
            ST_SUMS:
            begin
                cmd.sum_s  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                bit_next   = TOP_BIT;
                state_next = ST_TRY;
            end
            ST_TRY:
            begin
                if (stat.cand_over)
                begin
                    if (bit_reg == '0)
                        state_next = ST_STORE;
                    else
                        bit_next = bit_reg - BIT_W'(1);
                end
                else
                begin
                    cmd.mul_t2 = 1'b1;
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (bit_reg == '0)
                    state_next = ST_STORE;
                else
                begin
                    bit_next   = bit_reg - BIT_W'(1);
                    state_next = ST_TRY;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (comp_reg == COMP_Z)
                begin
                    comp_next = COMP_X;
                    if (tri_reg)
                    begin
                        vtx_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        tri_next   = 1'b1;
                        state_next = ST_SQP;
                    end
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = ST_INIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (vtx_reg == VTX_W'(VERTS - 1))
                        state_next = ST_IDLE;
                    else
                        vtx_next = vtx_reg + VTX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/terrain_cell_triangulator.sv */
// Top level of the terrain cell triangulator: controller plus datapath.
// Depends on tct_pkg, tct_ctrl and tct_datapath.
//
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | in_data  (cell_t, one grid cell)
//  output  | out       | out_valid/out_stall| out_data (vertex_t, six per cell)
//
// A cell passes the accept state, then per triangle the p and q squaring and the
// sum, per normal component an init, a 15-bit search on the one shared multiplier
// (per bit try with t^2, low and high product and compare, or try alone when the
// candidate is over range) and a store, then six vertex transfers, held on stall.
// Reset clears the controller and the patch maximum. A new cell is taken only
// once the sixth vertex of the previous one has been transferred.
`default_nettype none

module terrain_cell_triangulator
    import tct_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire cell_t   in_data,
    output logic         out_valid,
    input  wire logic    out_stall,
    output vertex_t      out_data
);

    cmd_t  cmd;
    stat_t stat;

    tct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tct_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_data (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .vertex    (out_data)
    );

endmodule

`default_nettype wire
